/* design/esdf_pkg.sv */
// Shared types, constants and saturating arithmetic for the edge scalar diffusion flux block.
package esdf_pkg;

    localparam int unsigned DW      = 64;
    localparam int unsigned MAX_DIMS = 3;
    localparam int unsigned MAX_VARS = 16;
    localparam int unsigned DIV_STEPS = 96;

    localparam logic signed [DW-1:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [DW-1:0] S_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [DW-1:0]        SIGN_MAG = 64'h8000_0000_0000_0000;

    localparam logic [1:0] OP_GEOM   = 2'd0;
    localparam logic [1:0] OP_FLOW   = 2'd1;
    localparam logic [1:0] OP_GRAD   = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    localparam logic [2:0] REG_NUM_DIMS  = 3'd0;
    localparam logic [2:0] REG_NUM_VARS  = 3'd1;
    localparam logic [2:0] REG_CORRECT   = 3'd2;
    localparam logic [2:0] REG_IMPLICIT  = 3'd3;
    localparam logic [2:0] REG_FLAME     = 3'd4;
    localparam logic [2:0] REG_TURB      = 3'd5;
    localparam logic [2:0] REG_INV_SCT   = 3'd6;

    localparam logic [62:0] INV_SCT_RESET = 63'd6163254236;

    typedef struct packed {
        logic                  ovf;
        logic signed [DW-1:0]  val;
    } sres_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } unit_cmd_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_MRND,
        U_DIV,
        U_DFIN
    } unit_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SKIP,
        S_GEO_EE,
        S_GEO_EN,
        S_GEO_DIV,
        S_FLOW_I,
        S_FLOW_J,
        S_GRAD_N,
        S_GRAD_E,
        S_FIN_T1,
        S_FIN_T2,
        S_FIN_LI,
        S_FIN_LJ,
        S_FIN_FLUX,
        S_FIN_DI,
        S_FIN_JI,
        S_FIN_DJ,
        S_FIN_JJ,
        S_OUT
    } state_t;

    function automatic sres_t sat_add(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
        logic signed [DW-1:0] r;
        sres_t s;
        r = a + b;
        s.ovf = 1'b0;
        s.val = r;
        if (a[DW-1] == b[DW-1] && r[DW-1] != a[DW-1])
        begin
            s.ovf = 1'b1;
            s.val = a[DW-1] ? S_MIN : S_MAX;
        end
        return s;
    endfunction

    function automatic sres_t sat_sub(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
        logic signed [DW-1:0] r;
        sres_t s;
        r = a - b;
        s.ovf = 1'b0;
        s.val = r;
        if (a[DW-1] != b[DW-1] && r[DW-1] != a[DW-1])
        begin
            s.ovf = 1'b1;
            s.val = a[DW-1] ? S_MIN : S_MAX;
        end
        return s;
    endfunction

    function automatic logic signed [DW-1:0] mean2(logic signed [DW-1:0] a,
                                                  logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        return s[DW:1];
    endfunction

    function automatic logic [DW-1:0] mag(logic signed [DW-1:0] a);
        return a[DW-1] ? (~a + 64'd1) : a;
    endfunction

    function automatic sres_t from_mag(logic neg, logic [DW-1:0] m);
        sres_t s;
        s.ovf = 1'b0;
        if (neg)
        begin
            if (m >= SIGN_MAG)
            begin
                s.ovf = (m != SIGN_MAG);
                s.val = S_MIN;
            end
            else
            begin
                s.val = ~m + 64'd1;
            end
        end
        else if (m >= SIGN_MAG)
        begin
            s.ovf = 1'b1;
            s.val = S_MAX;
        end
        else
        begin
            s.val = m;
        end
        return s;
    endfunction

endpackage

/* design/esdf_unit.sv */
// Shared multiply/divide unit: 32x32 partial-product multiplier and restoring divider.
module esdf_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  esdf_pkg::unit_cmd_t           cmd,
    input  logic signed [63:0]            a,
    input  logic signed [63:0]            b,
    output logic                          done,
    output logic signed [63:0]            res,
    output logic                          ovf
);
    import esdf_pkg::*;

    unit_state_t      state_reg, state_next;
    logic [6:0]       cnt_reg;
    logic [DW-1:0]    x_reg, y_reg;
    logic             neg_reg;
    logic [127:0]     acc_reg;
    logic [95:0]      num_reg;
    logic [95:0]      quo_reg;
    logic [DW-1:0]    rem_reg;
    logic             done_reg;
    logic signed [DW-1:0] res_reg;
    logic             ovf_reg;

    logic [31:0]      xs, ys;
    logic [63:0]      pp;
    logic [1:0]       sh;
    logic [127:0]     pp_wide;
    logic [127:0]     rnd;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_diff;
    logic             fits;
    sres_t            mul_fm, div_fm;

    always_comb
    begin
        xs       = cnt_reg[0] ? x_reg[63:32] : x_reg[31:0];
        ys       = cnt_reg[1] ? y_reg[63:32] : y_reg[31:0];
        pp       = xs * ys;
        sh       = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
        pp_wide  = {64'd0, pp} << {sh, 5'd0};
        rnd      = acc_reg + 128'h8000_0000;
        mul_fm   = from_mag(neg_reg, rnd[95:32]);
        rem_sh   = {rem_reg, num_reg[95]};
        rem_diff = rem_sh - {1'b0, y_reg};
        fits     = (rem_sh >= {1'b0, y_reg});
        div_fm   = from_mag(neg_reg, quo_reg[63:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = cmd.is_div ? U_DIV : U_MUL;
                end
            end
            U_MUL:
            begin
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = U_MRND;
                end
            end
            U_MRND:  state_next = U_IDLE;
            U_DIV:
            begin
                if (cnt_reg == 7'(DIV_STEPS - 1))
                begin
                    state_next = U_DFIN;
                end
            end
            U_DFIN:  state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == U_MRND) || (state_reg == U_DFIN);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                x_reg   <= mag(a);
                y_reg   <= mag(b);
                neg_reg <= a[DW-1] ^ b[DW-1];
                cnt_reg <= '0;
                acc_reg <= '0;
                num_reg <= {mag(a), 32'd0};
                quo_reg <= '0;
                rem_reg <= '0;
            end
            U_MUL:
            begin
                acc_reg <= acc_reg + pp_wide;
                cnt_reg <= cnt_reg + 7'd1;
            end
            U_MRND:
            begin
                if (rnd[127:96] != 32'd0)
                begin
                    ovf_reg <= 1'b1;
                    res_reg <= neg_reg ? S_MIN : S_MAX;
                end
                else
                begin
                    ovf_reg <= mul_fm.ovf;
                    res_reg <= mul_fm.val;
                end
            end
            U_DIV:
            begin
                rem_reg <= fits ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
                quo_reg <= {quo_reg[94:0], fits};
                num_reg <= {num_reg[94:0], 1'b0};
                cnt_reg <= cnt_reg + 7'd1;
            end
            U_DFIN:
            begin
                if (quo_reg[95:64] != 32'd0)
                begin
                    ovf_reg <= 1'b1;
                    res_reg <= neg_reg ? S_MIN : S_MAX;
                end
                else
                begin
                    ovf_reg <= div_fm.ovf;
                    res_reg <= div_fm.val;
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign ovf  = ovf_reg;

endmodule

/* design/edge_scalar_diffusion_flux.sv */
// Top level: edge diffusion flux sequencer around one shared multiply/divide unit.
// Each multiply or divide step that is issued holds the sequencer until the shared unit reports done.
// A dropped beat passes through the skip state; gradient, flow, geometry and finish beats
// run their unit steps in order, and a finish beat then waits in the output state.
// Throughput: one beat at a time; the next is taken once the sequencer is back in idle.
// Reset: asynchronous, active low; clears state, sticky flags and configuration.
module edge_scalar_diffusion_flux (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [447:0]  s_tdata,   // pos_i, pos_j, normal_comp, first_i, first_j, second_i, second_j
    input  logic [3:0]    s_tuser,   // op, dim_index
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [191:0]  m_tdata,   // flux, jac_i_diag, jac_j_diag
    output logic [4:0]    m_tuser,   // var_index, overflow
    output logic          m_tlast,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [62:0]   cfg_data
);
    import esdf_pkg::*;

    state_t state_reg, state_next;

    logic [1:0]   num_dims_reg;
    logic [4:0]   num_vars_reg;
    logic         correct_reg, implicit_reg, flame_reg, turb_mode_reg;
    logic [62:0]  inv_sct_reg;

    logic signed [DW-1:0] edge_vec_reg   [MAX_DIMS];
    logic signed [DW-1:0] normal_vec_reg [MAX_DIMS];
    logic signed [DW-1:0] dist_reg, proj_acc_reg, ratio_reg;
    logic signed [DW-1:0] dens_i_reg, dens_j_reg, turb_reg;
    logic signed [DW-1:0] gn_reg, ge_reg;
    logic [3:0]           var_count_reg;
    logic                 edge_ovf_reg, var_ovf_reg, fin_ovf_reg;

    logic [1:0]           d_reg;
    logic signed [DW-1:0] e_reg, mean_reg, fi_reg, fj_reg, si_reg, sj_reg;
    logic signed [DW-1:0] tmp_reg, aux_reg, proj_reg, q_reg, flux_reg, ji_reg, jj_reg;
    logic                 issued_reg;

    logic                 out_valid_reg;
    logic [191:0]         out_data_reg;
    logic [4:0]           out_user_reg;
    logic                 out_last_reg;

    logic [1:0]           in_op, in_dim;
    logic signed [DW-1:0] in_pi, in_pj, in_nc, in_fi, in_fj, in_si, in_sj;
    logic                 accept;
    logic [1:0]           nd;
    logic [4:0]           nv;
    logic                 in_range;
    sres_t                e_sub, fdiff, t_sub, p_sub, lam_add, add_alu, neg_alu;
    logic signed [DW-1:0] lam_val;

    unit_cmd_t            cmd;
    logic signed [DW-1:0] op_a, op_b;
    logic                 alu_done, alu_ovf;
    logic signed [DW-1:0] alu_res;
    logic                 unit_state, skip, step, out_free, last;
    logic [4:0]           vc_inc;

    always_comb
    begin
        in_op  = s_tuser[1:0];
        in_dim = s_tuser[3:2];
        in_pi  = s_tdata[63:0];
        in_pj  = s_tdata[127:64];
        in_nc  = s_tdata[191:128];
        in_fi  = s_tdata[255:192];
        in_fj  = s_tdata[319:256];
        in_si  = s_tdata[383:320];
        in_sj  = s_tdata[447:384];
        accept = s_tvalid && s_tready;
        nd     = (num_dims_reg == 2'd3) ? 2'd3 : 2'd2;
        nv     = (num_vars_reg == 5'd0) ? 5'd1 :
                 (num_vars_reg > 5'(MAX_VARS)) ? 5'(MAX_VARS) : num_vars_reg;
        in_range = (in_dim < nd);
        e_sub  = sat_sub(in_pj, in_pi);
        fdiff  = sat_sub(fj_reg, fi_reg);
        t_sub  = sat_sub(tmp_reg, alu_res);
        p_sub  = sat_sub(proj_reg, t_sub.val);
        lam_val = flame_reg ? mean2(si_reg, sj_reg) : mean2(tmp_reg, alu_res);
        lam_add = sat_add(lam_val, turb_reg);
        neg_alu = sat_sub('0, alu_res);
        vc_inc  = {1'b0, var_count_reg} + 5'd1;
        last    = (vc_inc >= nv);
        out_free = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        op_a = aux_reg;
        op_b = q_reg;
        add_alu = sat_add(gn_reg, alu_res);
        case (state_reg)
            S_GEO_EE:
            begin
                op_a = e_reg;
                op_b = e_reg;
                add_alu = sat_add(dist_reg, alu_res);
            end
            S_GEO_EN:
            begin
                op_a = e_reg;
                op_b = normal_vec_reg[d_reg];
                add_alu = sat_add(proj_acc_reg, alu_res);
            end
            S_GEO_DIV:
            begin
                op_a = proj_acc_reg;
                op_b = dist_reg;
            end
            S_FLOW_I:
            begin
                op_a = si_reg;
                op_b = {1'b0, inv_sct_reg};
            end
            S_FLOW_J:
            begin
                op_a = sj_reg;
                op_b = {1'b0, inv_sct_reg};
            end
            S_GRAD_N:
            begin
                op_a = mean_reg;
                op_b = normal_vec_reg[d_reg];
            end
            S_GRAD_E:
            begin
                op_a = mean_reg;
                op_b = edge_vec_reg[d_reg];
                add_alu = sat_add(ge_reg, alu_res);
            end
            S_FIN_T1:
            begin
                op_a = ge_reg;
                op_b = ratio_reg;
            end
            S_FIN_T2:
            begin
                op_a = fdiff.val;
                op_b = ratio_reg;
            end
            S_FIN_LI:
            begin
                op_a = dens_i_reg;
                op_b = si_reg;
            end
            S_FIN_LJ:
            begin
                op_a = dens_j_reg;
                op_b = sj_reg;
            end
            S_FIN_FLUX:
            begin
                op_a = aux_reg;
                op_b = proj_reg;
            end
            S_FIN_DI:
            begin
                op_a = ratio_reg;
                op_b = dens_i_reg;
            end
            S_FIN_DJ:
            begin
                op_a = ratio_reg;
                op_b = dens_j_reg;
            end
            default:
            begin
                op_a = aux_reg;
                op_b = q_reg;
            end
        endcase
    end

    always_comb
    begin
        unit_state = !(state_reg inside {S_IDLE, S_SKIP, S_OUT});
        skip = ((state_reg == S_GEO_DIV) && (dist_reg == '0)) ||
               ((state_reg == S_FIN_LI) && flame_reg) ||
               ((state_reg == S_FIN_DI) && (dens_i_reg == '0)) ||
               ((state_reg == S_FIN_DJ) && (dens_j_reg == '0));
        cmd.start  = unit_state && !skip && !issued_reg;
        cmd.is_div = (state_reg inside {S_GEO_DIV, S_FIN_DI, S_FIN_DJ});
        step = unit_state && (skip || (issued_reg && alu_done));
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_GEOM:   state_next = in_range ? S_GEO_EE : S_SKIP;
                        OP_FLOW:   state_next = turb_mode_reg ? S_FLOW_I : S_SKIP;
                        OP_GRAD:   state_next = in_range ? S_GRAD_N : S_SKIP;
                        default:   state_next = correct_reg ? S_FIN_T1 : S_FIN_LI;
                    endcase
                end
            end
            S_SKIP:  state_next = S_IDLE;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                if (step)
                begin
                    case (state_reg)
                        S_GEO_EE:   state_next = S_GEO_EN;
                        S_GEO_EN:   state_next = S_GEO_DIV;
                        S_FLOW_I:   state_next = S_FLOW_J;
                        S_GRAD_N:   state_next = correct_reg ? S_GRAD_E : S_IDLE;
                        S_FIN_T1:   state_next = S_FIN_T2;
                        S_FIN_T2:   state_next = S_FIN_LI;
                        S_FIN_LI:   state_next = flame_reg ? S_FIN_FLUX : S_FIN_LJ;
                        S_FIN_LJ:   state_next = S_FIN_FLUX;
                        S_FIN_FLUX: state_next = implicit_reg ? S_FIN_DI : S_OUT;
                        S_FIN_DI:   state_next = skip ? S_FIN_DJ : S_FIN_JI;
                        S_FIN_JI:   state_next = S_FIN_DJ;
                        S_FIN_DJ:   state_next = skip ? S_OUT : S_FIN_JJ;
                        S_FIN_JJ:   state_next = S_OUT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            num_dims_reg  <= 2'd3;
            num_vars_reg  <= 5'd1;
            correct_reg   <= 1'b0;
            implicit_reg  <= 1'b0;
            flame_reg     <= 1'b0;
            turb_mode_reg <= 1'b0;
            inv_sct_reg   <= INV_SCT_RESET;
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                edge_vec_reg[k]   <= '0;
                normal_vec_reg[k] <= '0;
            end
            dist_reg      <= '0;
            proj_acc_reg  <= '0;
            ratio_reg     <= '0;
            dens_i_reg    <= '0;
            dens_j_reg    <= '0;
            turb_reg      <= '0;
            gn_reg        <= '0;
            ge_reg        <= '0;
            var_count_reg <= '0;
            edge_ovf_reg  <= 1'b0;
            var_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.start)
            begin
                issued_reg <= 1'b1;
            end
            else if (step)
            begin
                issued_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_NUM_DIMS: num_dims_reg  <= cfg_data[1:0];
                    REG_NUM_VARS: num_vars_reg  <= cfg_data[4:0];
                    REG_CORRECT:  correct_reg   <= cfg_data[0];
                    REG_IMPLICIT: implicit_reg  <= cfg_data[0];
                    REG_FLAME:    flame_reg     <= cfg_data[0];
                    REG_TURB:     turb_mode_reg <= cfg_data[0];
                    REG_INV_SCT:  inv_sct_reg   <= cfg_data;
                    default:      ;
                endcase
            end

            if (accept)
            begin
                case (in_op)
                    OP_GEOM:
                    begin
                        for (int k = 0; k < MAX_DIMS; k++)
                        begin
                            if (in_range && (in_dim == 2'(k)))
                            begin
                                edge_vec_reg[k]   <= e_sub.val;
                                normal_vec_reg[k] <= in_nc;
                            end
                            else if (in_dim == 2'd0)
                            begin
                                edge_vec_reg[k]   <= '0;
                                normal_vec_reg[k] <= '0;
                            end
                        end
                        if (in_dim == 2'd0)
                        begin
                            dist_reg     <= '0;
                            proj_acc_reg <= '0;
                        end
                        edge_ovf_reg <= ((in_dim == 2'd0) ? 1'b0 : edge_ovf_reg) |
                                        (in_range & e_sub.ovf);
                    end
                    OP_FLOW:
                    begin
                        dens_i_reg    <= in_fi;
                        dens_j_reg    <= in_fj;
                        turb_reg      <= '0;
                        gn_reg        <= '0;
                        ge_reg        <= '0;
                        var_count_reg <= '0;
                        var_ovf_reg   <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (step)
            begin
                case (state_reg)
                    S_GEO_EE:
                    begin
                        dist_reg     <= add_alu.val;
                        edge_ovf_reg <= edge_ovf_reg | alu_ovf | add_alu.ovf;
                    end
                    S_GEO_EN:
                    begin
                        proj_acc_reg <= add_alu.val;
                        edge_ovf_reg <= edge_ovf_reg | alu_ovf | add_alu.ovf;
                    end
                    S_GEO_DIV:
                    begin
                        ratio_reg    <= skip ? '0 : alu_res;
                        edge_ovf_reg <= edge_ovf_reg | (!skip & alu_ovf);
                    end
                    S_FLOW_I:
                    begin
                        edge_ovf_reg <= edge_ovf_reg | alu_ovf;
                    end
                    S_FLOW_J:
                    begin
                        turb_reg     <= mean2(tmp_reg, alu_res);
                        edge_ovf_reg <= edge_ovf_reg | alu_ovf;
                    end
                    S_GRAD_N:
                    begin
                        gn_reg      <= add_alu.val;
                        var_ovf_reg <= var_ovf_reg | alu_ovf | add_alu.ovf;
                    end
                    S_GRAD_E:
                    begin
                        ge_reg      <= add_alu.val;
                        var_ovf_reg <= var_ovf_reg | alu_ovf | add_alu.ovf;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                var_count_reg <= last ? 4'd0 : vc_inc[3:0];
                gn_reg        <= '0;
                ge_reg        <= '0;
                var_ovf_reg   <= 1'b0;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg    <= in_dim;
            e_reg    <= e_sub.val;
            mean_reg <= mean2(in_fi, in_fj);
            fi_reg   <= in_fi;
            fj_reg   <= in_fj;
            si_reg   <= in_si;
            sj_reg   <= in_sj;
            proj_reg <= gn_reg;
            fin_ovf_reg <= edge_ovf_reg | var_ovf_reg;
            ji_reg   <= '0;
            jj_reg   <= '0;
        end
        if (step)
        begin
            case (state_reg)
                S_FLOW_I:   tmp_reg <= alu_res;
                S_FIN_T1:
                begin
                    tmp_reg     <= alu_res;
                    fin_ovf_reg <= fin_ovf_reg | alu_ovf;
                end
                S_FIN_T2:
                begin
                    proj_reg    <= p_sub.val;
                    fin_ovf_reg <= fin_ovf_reg | alu_ovf | fdiff.ovf | t_sub.ovf | p_sub.ovf;
                end
                S_FIN_LI:
                begin
                    if (skip)
                    begin
                        aux_reg     <= lam_add.val;
                        fin_ovf_reg <= fin_ovf_reg | lam_add.ovf;
                    end
                    else
                    begin
                        tmp_reg     <= alu_res;
                        fin_ovf_reg <= fin_ovf_reg | alu_ovf;
                    end
                end
                S_FIN_LJ:
                begin
                    aux_reg     <= lam_add.val;
                    fin_ovf_reg <= fin_ovf_reg | alu_ovf | lam_add.ovf;
                end
                S_FIN_FLUX:
                begin
                    flux_reg    <= alu_res;
                    fin_ovf_reg <= fin_ovf_reg | alu_ovf;
                end
                S_FIN_DI, S_FIN_DJ:
                begin
                    q_reg       <= alu_res;
                    fin_ovf_reg <= fin_ovf_reg | (!skip & alu_ovf);
                end
                S_FIN_JI:
                begin
                    ji_reg      <= neg_alu.val;
                    fin_ovf_reg <= fin_ovf_reg | alu_ovf | neg_alu.ovf;
                end
                S_FIN_JJ:
                begin
                    jj_reg      <= alu_res;
                    fin_ovf_reg <= fin_ovf_reg | alu_ovf;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg <= {jj_reg, ji_reg, flux_reg};
            out_user_reg <= {fin_ovf_reg, var_count_reg};
            out_last_reg <= last;
        end
    end

    esdf_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .a     (op_a),
        .b     (op_b),
        .done  (alu_done),
        .res   (alu_res),
        .ovf   (alu_ovf)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* design/esdf_checker.sv */
// Port-level checker for the edge scalar diffusion flux block, bound to the top level.
module esdf_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [191:0]  m_tdata
);

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous beat still in work");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a busy period");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

bind edge_scalar_diffusion_flux esdf_checker u_esdf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb_edge_scalar_diffusion_flux.sv */
// Self-checking testbench for the edge scalar diffusion flux block.
`timescale 1ns / 1ps

module tb_edge_scalar_diffusion_flux;
    import esdf_pkg::*;

    typedef logic signed [63:0] q_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] dim;
        q_t pi;
        q_t pj;
        q_t nc;
        q_t fi;
        q_t fj;
        q_t si;
        q_t sj;
    } beat_in_t;

    typedef struct packed {
        logic [3:0] var_index;
        q_t flux;
        q_t jac_i;
        q_t jac_j;
        logic last_var;
        logic overflow;
    } flux_beat_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [447:0] s_tdata;
    logic [3:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [191:0] m_tdata;
    logic [4:0] m_tuser;
    logic m_tlast;
    logic cfg_wr_en;
    logic [2:0] cfg_index;
    logic [62:0] cfg_data;

    edge_scalar_diffusion_flux dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [1:0] c_dims;
    logic [4:0] c_vars;
    logic c_corr, c_impl, c_flame, c_turb;
    logic [62:0] c_inv;
    q_t edge_v[3];
    q_t norm_v[3];
    q_t dist_sq, proj_sum, ratio, rho_i, rho_j, mu_t, gn_sum, ge_sum;
    logic [3:0] var_cnt;
    logic edge_flag, var_flag;

    flux_beat_t expected_flux[$];
    int errors;
    int mismatches;
    int results_seen;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("FAIL");
        $finish;
    end

    function automatic q_t add_sat(q_t a, q_t b, inout logic f);
        q_t r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
        begin
            f = 1'b1;
            r = a[63] ? S_MIN : S_MAX;
        end
        return r;
    endfunction

    function automatic q_t sub_sat(q_t a, q_t b, inout logic f);
        q_t r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
        begin
            f = 1'b1;
            r = a[63] ? S_MIN : S_MAX;
        end
        return r;
    endfunction

    function automatic q_t half_sum(q_t a, q_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        return s[64:1];
    endfunction

    function automatic q_t signed_from_mag(logic neg, logic [63:0] m, inout logic f);
        if (neg)
        begin
            if (m >= 64'h8000_0000_0000_0000)
            begin
                if (m != 64'h8000_0000_0000_0000)
                    f = 1'b1;
                return S_MIN;
            end
            return -$signed(m);
        end
        if (m[63])
        begin
            f = 1'b1;
            return S_MAX;
        end
        return $signed(m);
    endfunction

    function automatic q_t mul_q(q_t a, q_t b, inout logic f);
        logic [63:0] x, y;
        logic [127:0] p;
        logic neg;
        x = a[63] ? -a : a;
        y = b[63] ? -b : b;
        neg = a[63] != b[63];
        p = x * y + 128'h8000_0000;
        if (p[127:96] != 0)
        begin
            f = 1'b1;
            return neg ? S_MIN : S_MAX;
        end
        return signed_from_mag(neg, p[95:32], f);
    endfunction

    function automatic q_t div_q(q_t a, q_t b, inout logic f);
        logic [63:0] x, y;
        logic [127:0] q;
        logic neg;
        x = a[63] ? -a : a;
        y = b[63] ? -b : b;
        neg = a[63] != b[63];
        q = {32'd0, x, 32'd0} / {64'd0, y};
        if (q[127:64] != 0)
        begin
            f = 1'b1;
            return neg ? S_MIN : S_MAX;
        end
        return signed_from_mag(neg, q[63:0], f);
    endfunction

    task automatic model_reset();
        c_dims = 2'd3; c_vars = 5'd1; c_corr = 0; c_impl = 0; c_flame = 0; c_turb = 0;
        c_inv = INV_SCT_RESET;
        for (int k = 0; k < 3; k++)
        begin
            edge_v[k] = 0;
            norm_v[k] = 0;
        end
        dist_sq = 0; proj_sum = 0; ratio = 0; rho_i = 0; rho_j = 0; mu_t = 0;
        gn_sum = 0; ge_sum = 0; var_cnt = 0; edge_flag = 0; var_flag = 0;
    endtask

    function automatic int dims_used();
        return (c_dims < 2) ? 2 : c_dims;
    endfunction

    function automatic int vars_used();
        return (c_vars == 0) ? 1 : (c_vars > 16 ? 16 : c_vars);
    endfunction

    task automatic predict_flux(beat_in_t b);
        flux_beat_t r;
        logic f;
        q_t e, mean, proj, t1, t2, lam, dif, ji, jj;
        int nv;
        case (b.op)
            OP_GEOM:
            begin
                if (b.dim == 0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        edge_v[k] = 0;
                        norm_v[k] = 0;
                    end
                    dist_sq = 0; proj_sum = 0; edge_flag = 0;
                end
                if (b.dim < dims_used())
                begin
                    e = sub_sat(b.pj, b.pi, edge_flag);
                    edge_v[b.dim] = e;
                    norm_v[b.dim] = b.nc;
                    dist_sq = add_sat(dist_sq, mul_q(e, e, edge_flag), edge_flag);
                    proj_sum = add_sat(proj_sum, mul_q(e, b.nc, edge_flag), edge_flag);
                    ratio = (dist_sq == 0) ? 0 : div_q(proj_sum, dist_sq, edge_flag);
                end
            end
            OP_FLOW:
            begin
                rho_i = b.fi;
                rho_j = b.fj;
                if (c_turb)
                    mu_t = half_sum(mul_q(b.si, $signed({1'b0, c_inv}), edge_flag),
                                    mul_q(b.sj, $signed({1'b0, c_inv}), edge_flag));
                else
                    mu_t = 0;
                gn_sum = 0; ge_sum = 0; var_cnt = 0; var_flag = 0;
            end
            OP_GRAD:
            begin
                if (b.dim < dims_used())
                begin
                    mean = half_sum(b.fi, b.fj);
                    gn_sum = add_sat(gn_sum, mul_q(mean, norm_v[b.dim], var_flag), var_flag);
                    if (c_corr)
                        ge_sum = add_sat(ge_sum, mul_q(mean, edge_v[b.dim], var_flag),
                                         var_flag);
                end
            end
            default:
            begin
                f = edge_flag | var_flag;
                proj = gn_sum;
                ji = 0;
                jj = 0;
                nv = vars_used();
                if (c_corr)
                begin
                    t1 = mul_q(ge_sum, ratio, f);
                    t2 = mul_q(sub_sat(b.fj, b.fi, f), ratio, f);
                    proj = sub_sat(proj, sub_sat(t1, t2, f), f);
                end
                if (c_flame)
                    lam = half_sum(b.si, b.sj);
                else
                    lam = half_sum(mul_q(rho_i, b.si, f), mul_q(rho_j, b.sj, f));
                dif = add_sat(lam, mu_t, f);
                r.flux = mul_q(dif, proj, f);
                if (c_impl)
                begin
                    if (rho_i != 0)
                        ji = sub_sat(0, mul_q(dif, div_q(ratio, rho_i, f), f), f);
                    if (rho_j != 0)
                        jj = mul_q(dif, div_q(ratio, rho_j, f), f);
                end
                r.var_index = var_cnt;
                r.jac_i = ji;
                r.jac_j = jj;
                r.last_var = (int'(var_cnt) + 1 >= nv);
                r.overflow = f;
                var_cnt = r.last_var ? 4'd0 : var_cnt + 4'd1;
                gn_sum = 0; ge_sum = 0; var_flag = 0;
                expected_flux.push_back(r);
            end
        endcase
    endtask

    task automatic send_beat(beat_in_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {b.dim, b.op};
        s_tdata <= {b.sj, b.si, b.fj, b.fi, b.nc, b.pj, b.pi};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_flux(b);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_flux.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [62:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_NUM_DIMS: c_dims = val[1:0];
            REG_NUM_VARS: c_vars = val[4:0];
            REG_CORRECT: c_corr = val[0];
            REG_IMPLICIT: c_impl = val[0];
            REG_FLAME: c_flame = val[0];
            REG_TURB: c_turb = val[0];
            REG_INV_SCT: c_inv = val;
            default: ;
        endcase
    endtask

    function automatic q_t rand_q();
        q_t v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return v;
            1: return S_MAX;
            2: return S_MIN;
            3: return 0;
            default: return $signed(v) >>> $urandom_range(40, 20);
        endcase
    endfunction

    function automatic q_t rand_small();
        return $signed({$urandom, $urandom}) >>> $urandom_range(36, 24);
    endfunction

    function automatic beat_in_t make_beat(logic [1:0] op, logic [1:0] dim, bit wild);
        beat_in_t b;
        b.op = op;
        b.dim = dim;
        b.pi = wild ? rand_q() : rand_small();
        b.pj = wild ? rand_q() : rand_small();
        b.nc = wild ? rand_q() : rand_small();
        b.fi = wild ? rand_q() : rand_small();
        b.fj = wild ? rand_q() : rand_small();
        b.si = wild ? rand_q() : rand_small();
        b.sj = wild ? rand_q() : rand_small();
        if (op == OP_FLOW && !wild && $urandom_range(9) == 0)
            b.fi = 0;
        return b;
    endfunction

    task automatic send_edge(bit wild);
        int nd, nv;
        nd = dims_used();
        nv = vars_used() + ($urandom_range(9) == 0);
        for (int d = 0; d < nd; d++)
            send_beat(make_beat(OP_GEOM, d[1:0], wild));
        if ($urandom_range(5) == 0)
            send_beat(make_beat(OP_GEOM, 2'd3, wild));
        send_beat(make_beat(OP_FLOW, 2'd0, wild));
        for (int v = 0; v < nv; v++)
        begin
            for (int d = 0; d < nd; d++)
                send_beat(make_beat(OP_GRAD, d[1:0], wild));
            send_beat(make_beat(OP_FINISH, 2'($urandom_range(3)), wild));
        end
    endtask

    task automatic test_directed();
        beat_in_t b;
        send_beat(make_beat(OP_FINISH, 0, 0));
        b = make_beat(OP_GEOM, 0, 0);
        b.pi = 0; b.pj = 0;
        send_beat(b);
        b.dim = 1;
        send_beat(b);
        b.dim = 2;
        send_beat(b);
        b = make_beat(OP_FLOW, 0, 0);
        b.fi = 0; b.fj = 0;
        send_beat(b);
        send_beat(make_beat(OP_GRAD, 0, 0));
        send_beat(make_beat(OP_GRAD, 3, 1));
        send_beat(make_beat(OP_FINISH, 0, 0));
        send_beat(make_beat(OP_FINISH, 0, 0));
        b = make_beat(OP_GEOM, 0, 0);
        b.pi = S_MIN; b.pj = S_MAX; b.nc = S_MAX;
        send_beat(b);
        b.dim = 1; b.pi = S_MAX; b.pj = S_MIN; b.nc = S_MIN;
        send_beat(b);
        b = make_beat(OP_FLOW, 0, 1);
        b.fi = S_MAX; b.fj = S_MIN; b.si = S_MAX; b.sj = S_MIN;
        send_beat(b);
        b = make_beat(OP_GRAD, 0, 0);
        b.fi = S_MAX; b.fj = S_MAX;
        send_beat(b);
        b.fi = S_MIN; b.fj = S_MIN; b.dim = 1;
        send_beat(b);
        b = make_beat(OP_FINISH, 0, 0);
        b.fi = S_MIN; b.fj = S_MAX; b.si = S_MAX; b.sj = S_MAX;
        send_beat(b);
    endtask

    task automatic test_config_sweep();
        write_reg(REG_IMPLICIT, 1);
        write_reg(REG_CORRECT, 1);
        write_reg(REG_TURB, 1);
        write_reg(REG_NUM_VARS, 3);
        test_directed();
        write_reg(REG_NUM_DIMS, 2);
        write_reg(REG_FLAME, 1);
        write_reg(REG_INV_SCT, 63'h7FFF_FFFF_FFFF_FFFF);
        send_edge(1);
        write_reg(REG_NUM_DIMS, 0);
        write_reg(REG_NUM_VARS, 0);
        write_reg(REG_INV_SCT, 0);
        send_edge(0);
        write_reg(REG_NUM_VARS, 31);
        write_reg(REG_NUM_DIMS, 3);
        send_edge(0);
    endtask

    task automatic test_random_edges(int n_items);
        int goal;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            if ($urandom_range(9) == 0)
            begin
                write_reg(REG_NUM_DIMS, 63'($urandom_range(3)));
                write_reg(REG_NUM_VARS, $urandom_range(4) == 0 ? 63'($urandom_range(31))
                                                                : 63'($urandom_range(4)));
                write_reg(REG_CORRECT, 63'($urandom_range(1)));
                write_reg(REG_IMPLICIT, 63'($urandom_range(1)));
                write_reg(REG_FLAME, 63'($urandom_range(1)));
                write_reg(REG_TURB, 63'($urandom_range(1)));
                write_reg(REG_INV_SCT, 63'({$urandom, $urandom} >> $urandom_range(40, 24)));
            end
            if ($urandom_range(7) == 0)
                send_beat(make_beat(2'($urandom_range(3)), 2'($urandom_range(3)), 1));
            else
                send_edge($urandom_range(4) == 0);
            if ($urandom_range(19) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        model_reset();
        send_idle_pct = 35;
        recv_idle_pct = 83;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random_edges(400);
        send_idle_pct = 83;
        recv_idle_pct = 35;
        test_random_edges(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_edges(400);
        wait_drained();
        $display("Sent %0d items over several register settings, checked %0d flux beats.",
                 items_sent, results_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        flux_beat_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.var_index = m_tuser[3:0];
            got.overflow = m_tuser[4];
            got.flux = m_tdata[63:0];
            got.jac_i = m_tdata[127:64];
            got.jac_j = m_tdata[191:128];
            got.last_var = m_tlast;
            results_seen++;
            if (expected_flux.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected flux beat %p", got);
            end
            else
            begin
                want = expected_flux.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("flux mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

endmodule
